>>> hdl/pidd_pkg.sv
`default_nettype none
package pidd_pkg;

    // Stream decode phases
    typedef enum logic [2:0]
    {
        PH_WIDTH,
        PH_HEIGHT,
        PH_CODE,
        PH_PALETTE,
        PH_PIXELS,
        PH_IDLE
    } phase_t;

    // Per-byte sequencer states
    typedef enum logic [1:0]
    {
        SQ_IDLE,
        SQ_INDEX,
        SQ_COLOR,
        SQ_FLUSH
    } seq_t;

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ORIGIN_X      = 3'd0;
    localparam cfg_idx_t CFG_ORIGIN_Y      = 3'd1;
    localparam cfg_idx_t CFG_PIXEL_SCALE   = 3'd2;
    localparam cfg_idx_t CFG_SCREEN_WIDTH  = 3'd3;
    localparam cfg_idx_t CFG_SCREEN_HEIGHT = 3'd4;

    localparam logic [12:0] SCREEN_MAX = 13'd4096;

    // Built-in palette selectors (code -1, -2, -3)
    localparam logic [7:0] CODE_ROM_DMG  = 8'hFF;
    localparam logic [7:0] CODE_ROM_GRAY = 8'hFE;
    localparam logic [7:0] CODE_ROM_CGA  = 8'hFD;
    localparam logic [1:0] ROM_DMG  = 2'd0;
    localparam logic [1:0] ROM_GRAY = 2'd1;
    localparam logic [1:0] ROM_CGA  = 2'd2;
    localparam logic [6:0] ROM_SMALL_SIZE = 7'd4;
    localparam logic [6:0] ROM_CGA_SIZE   = 7'd16;

    localparam logic [23:0] DMG_PAL [4] = '{24'h0F380F, 24'h306230, 24'h8BAC0F, 24'h9BBC0F};
    localparam logic [23:0] GRAY_PAL [4] = '{24'h000000, 24'h555555, 24'hAAAAAA, 24'hFFFFFF};
    localparam logic [23:0] CGA_PAL [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAAAA00, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF};

    // One fill rectangle
    typedef struct packed
    {
        logic [11:0] x_start;
        logic [11:0] y_start;
        logic [12:0] x_end;
        logic [12:0] y_end;
        logic [23:0] color;
    } rect_t;

    // Smallest index width (1..7) whose code space holds n values
    function automatic logic [2:0] width_for(input logic [7:0] n);
        logic [2:0] b;
        b = 3'd1;
        for (int k = 0; k < 6; k++)
        begin
            if ((9'd1 << b) < {1'b0, n})
            begin
                b = b + 3'd1;
            end
        end
        return b;
    endfunction

    // Look up a built-in palette color
    function automatic logic [23:0] rom_color(input logic [1:0] id, input logic [3:0] i);
        logic [23:0] c;
        unique case (id)
            ROM_DMG:  c = DMG_PAL[i[1:0]];
            ROM_GRAY: c = GRAY_PAL[i[1:0]];
            default:  c = CGA_PAL[i];
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> hdl/pidd_ram.sv
`default_nettype none
module pidd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 127
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/packed_index_image_decoder_unit.sv
`default_nettype none
// Packed-index image decoder. Bytes of an image stream (width, height, signed
// palette code, inline RGB triples, then packed MSB-first pixel indices) enter
// one transaction at a time; each drawn pixel leaves as a clipped fill
// rectangle, with last_of_run set on the final rectangle of its byte. While
// the index sequencer works through a pixel byte (up to 8 indices) in_stall
// is held; the sequencer reads the palette RAM once per index and uses its
// registered read data in the following state, and a stalled output holds it.
// The inline palette lives in a single-port-write, registered-read RAM of
// PALETTE_DEPTH entries; built-in palettes come from constant tables.
module packed_index_image_decoder_unit #(
    parameter int PALETTE_DEPTH = 127
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        image_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      rect_x_start,
    output logic [11:0]      rect_y_start,
    output logic [12:0]      rect_x_end,
    output logic [12:0]      rect_y_end,
    output logic [23:0]      fill_color,
    output logic             last_of_run,
    input  wire logic        cfg_we,
    input  wire pidd_pkg::cfg_idx_t cfg_index,
    input  wire logic [12:0] cfg_data
);
    import pidd_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [7:0] DEPTH_MAX = 8'(PALETTE_DEPTH);

    // Configuration
    logic [11:0] origin_x_reg, origin_y_reg;
    logic [4:0]  scale_reg;
    logic [12:0] screen_w_reg, screen_h_reg;

    // Decode state
    phase_t      phase_reg, phase_next;
    logic [7:0]  width_reg, width_next, height_reg, height_next;
    logic [6:0]  count_reg, count_next, fill_reg, fill_next;
    logic [1:0]  tbi_reg, tbi_next;
    logic [15:0] partial_reg, partial_next;
    logic [2:0]  iw_reg, iw_next;
    logic [13:0] bits_reg, bits_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  row_reg, row_next, col_reg, col_next;
    logic        rom_reg, rom_next;
    logic [1:0]  rom_id_reg, rom_id_next;

    // Sequencer and datapath
    seq_t        sq_reg, sq_next;
    logic [6:0]  idx_reg, idx_next;
    logic [15:0] px_reg, px_next, py_reg, py_next;
    rect_t       cand_reg, cand_next, out_reg, out_next;
    logic        cand_valid_reg, cand_valid_next;
    logic        out_valid_reg, out_valid_next, out_last_reg, out_last_next;

    logic        accept, out_free;
    logic        ram_we;
    logic [23:0] ram_rdata;

    // Index extraction
    logic [3:0]  sh;
    logic [6:0]  idx_cur;
    logic        emit_cur, done_cur, more_idx;
    logic [12:0] prod_x, prod_y;

    // Clipping
    logic [12:0] sw, sh_lim;
    logic [15:0] x1, y1, x2raw, y2raw, x2, y2;
    logic        empty;
    rect_t       rect_new;

    logic        enter_px;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (sq_reg != SQ_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign sh       = cnt_reg - {1'b0, iw_reg};
    assign idx_cur  = 7'((bits_reg >> sh) & ((14'd1 << iw_reg) - 14'd1));
    assign emit_cur = idx_cur < count_reg;
    assign done_cur = ({1'b0, col_reg} + 9'd1 >= {1'b0, width_reg})
                      && ({1'b0, row_reg} + 9'd1 >= {1'b0, height_reg});
    assign more_idx = (phase_reg == PH_PIXELS) && (cnt_reg >= {1'b0, iw_reg});
    assign prod_x   = 13'(col_reg) * 13'(scale_reg);
    assign prod_y   = 13'(row_reg) * 13'(scale_reg);

    // Clip the registered position against the screen
    always_comb
    begin
        sw     = (screen_w_reg > SCREEN_MAX) ? SCREEN_MAX : screen_w_reg;
        sh_lim = (screen_h_reg > SCREEN_MAX) ? SCREEN_MAX : screen_h_reg;
        x2raw  = px_reg + {11'd0, scale_reg};
        y2raw  = py_reg + {11'd0, scale_reg};
        x1     = px_reg[15] ? 16'd0 : px_reg;
        y1     = py_reg[15] ? 16'd0 : py_reg;
        x2     = ($signed(x2raw) > $signed({3'd0, sw})) ? {3'd0, sw} : x2raw;
        y2     = ($signed(y2raw) > $signed({3'd0, sh_lim})) ? {3'd0, sh_lim} : y2raw;
        empty  = ($signed(x1) >= $signed(x2)) || ($signed(y1) >= $signed(y2));
        rect_new.x_start = x1[11:0];
        rect_new.y_start = y1[11:0];
        rect_new.x_end   = x2[12:0];
        rect_new.y_end   = y2[12:0];
        rect_new.color   = rom_reg ? rom_color(rom_id_reg, idx_reg[3:0]) : ram_rdata;
    end

    // Next sequencer state
    always_comb
    begin
        sq_next = sq_reg;
        unique case (sq_reg)
            SQ_IDLE:
            begin
                if (accept && phase_next == PH_PIXELS && phase_reg == PH_PIXELS
                    && !image_start)
                begin
                    sq_next = SQ_INDEX;
                end
            end
            SQ_INDEX:
            begin
                if (emit_cur)
                begin
                    sq_next = SQ_COLOR;
                end
                else if (!done_cur && (sh >= {1'b0, iw_reg}))
                begin
                    sq_next = SQ_INDEX;
                end
                else
                begin
                    sq_next = SQ_FLUSH;
                end
            end
            SQ_COLOR:
            begin
                if (empty || !cand_valid_reg || out_free)
                begin
                    sq_next = more_idx ? SQ_INDEX : SQ_FLUSH;
                end
            end
            SQ_FLUSH:
            begin
                if (!cand_valid_reg || out_free)
                begin
                    sq_next = SQ_IDLE;
                end
            end
            default: sq_next = SQ_IDLE;
        endcase
    end

    // Decode and datapath next values
    always_comb
    begin
        phase_next      = phase_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        tbi_next        = tbi_reg;
        partial_next    = partial_reg;
        iw_next         = iw_reg;
        bits_next       = bits_reg;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        rom_next        = rom_reg;
        rom_id_next     = rom_id_reg;
        idx_next        = idx_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        cand_next       = cand_reg;
        cand_valid_next = cand_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ram_we          = 1'b0;
        enter_px        = 1'b0;

        unique case (sq_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    unique case (image_start ? PH_WIDTH : phase_reg)
                        PH_WIDTH:
                        begin
                            width_next   = data_byte;
                            height_next  = 8'd0;
                            count_next   = 7'd0;
                            fill_next    = 7'd0;
                            tbi_next     = 2'd0;
                            partial_next = 16'd0;
                            iw_next      = 3'd1;
                            bits_next    = 14'd0;
                            cnt_next     = 4'd0;
                            row_next     = 8'd0;
                            col_next     = 8'd0;
                            phase_next   = PH_HEIGHT;
                        end
                        PH_HEIGHT:
                        begin
                            height_next = data_byte;
                            phase_next  = PH_CODE;
                        end
                        PH_CODE:
                        begin
                            if (data_byte == CODE_ROM_DMG || data_byte == CODE_ROM_GRAY)
                            begin
                                rom_next    = 1'b1;
                                rom_id_next = (data_byte == CODE_ROM_DMG) ? ROM_DMG
                                                                          : ROM_GRAY;
                                count_next  = ROM_SMALL_SIZE;
                                enter_px    = 1'b1;
                            end
                            else if (data_byte == CODE_ROM_CGA)
                            begin
                                rom_next    = 1'b1;
                                rom_id_next = ROM_CGA;
                                count_next  = ROM_CGA_SIZE;
                                enter_px    = 1'b1;
                            end
                            else if (data_byte[7] || data_byte > DEPTH_MAX)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                rom_next   = 1'b0;
                                count_next = data_byte[6:0];
                                fill_next  = 7'd0;
                                tbi_next   = 2'd0;
                                if (data_byte == 8'd0)
                                begin
                                    enter_px = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_PALETTE;
                                end
                            end
                        end
                        PH_PALETTE:
                        begin
                            if (tbi_reg < 2'd2)
                            begin
                                partial_next = {partial_reg[7:0], data_byte};
                                tbi_next     = tbi_reg + 2'd1;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                tbi_next     = 2'd0;
                                partial_next = 16'd0;
                                fill_next    = fill_reg + 7'd1;
                                if (fill_reg + 7'd1 >= count_reg)
                                begin
                                    enter_px = 1'b1;
                                end
                            end
                        end
                        PH_PIXELS:
                        begin
                            bits_next = {bits_reg[5:0], data_byte};
                            cnt_next  = cnt_reg + 4'd8;
                        end
                        default: ;
                    endcase

                    // Start pixel decode after the palette is known
                    if (enter_px)
                    begin
                        iw_next    = width_for({1'b0, count_next} + 8'd1);
                        bits_next  = 14'd0;
                        cnt_next   = 4'd0;
                        row_next   = 8'd0;
                        col_next   = 8'd0;
                        phase_next = (width_reg == 8'd0 || height_next == 8'd0)
                                     ? PH_IDLE : PH_PIXELS;
                    end
                end
            end
            SQ_INDEX:
            begin
                // Take one index and advance the pixel position
                idx_next  = idx_cur;
                px_next   = {{4{origin_x_reg[11]}}, origin_x_reg} + {3'd0, prod_x};
                py_next   = {{4{origin_y_reg[11]}}, origin_y_reg} + {3'd0, prod_y};
                cnt_next  = sh;
                bits_next = bits_reg & ((14'd1 << sh) - 14'd1);
                if ({1'b0, col_reg} + 9'd1 >= {1'b0, width_reg})
                begin
                    col_next = 8'd0;
                    row_next = row_reg + 8'd1;
                    if (done_cur)
                    begin
                        bits_next  = 14'd0;
                        cnt_next   = 4'd0;
                        phase_next = PH_IDLE;
                    end
                end
                else
                begin
                    col_next = col_reg + 8'd1;
                end
            end
            SQ_COLOR:
            begin
                // Hold the newest rectangle until the byte's last one is known
                if (!empty)
                begin
                    if (!cand_valid_reg)
                    begin
                        cand_next       = rect_new;
                        cand_valid_next = 1'b1;
                    end
                    else if (out_free)
                    begin
                        out_next       = cand_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                        cand_next      = rect_new;
                    end
                end
            end
            SQ_FLUSH:
            begin
                if (cand_valid_reg && out_free)
                begin
                    out_next        = cand_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    cand_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Palette memory
    pidd_ram #(
        .WIDTH(24),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data ({partial_reg, data_byte}),
        .rd_en   (sq_reg == SQ_INDEX),
        .rd_addr (idx_cur[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= 12'd0;
            origin_y_reg <= 12'd0;
            scale_reg    <= 5'd1;
            screen_w_reg <= 13'd320;
            screen_h_reg <= 13'd240;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:      origin_x_reg <= cfg_data[11:0];
                CFG_ORIGIN_Y:      origin_y_reg <= cfg_data[11:0];
                CFG_PIXEL_SCALE:   scale_reg    <= cfg_data[4:0];
                CFG_SCREEN_WIDTH:  screen_w_reg <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg         <= SQ_IDLE;
            phase_reg      <= PH_WIDTH;
            width_reg      <= 8'd0;
            height_reg     <= 8'd0;
            count_reg      <= 7'd0;
            fill_reg       <= 7'd0;
            tbi_reg        <= 2'd0;
            partial_reg    <= 16'd0;
            iw_reg         <= 3'd1;
            bits_reg       <= 14'd0;
            cnt_reg        <= 4'd0;
            row_reg        <= 8'd0;
            col_reg        <= 8'd0;
            rom_reg        <= 1'b0;
            rom_id_reg     <= ROM_DMG;
            cand_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sq_reg         <= sq_next;
            phase_reg      <= phase_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            tbi_reg        <= tbi_next;
            partial_reg    <= partial_next;
            iw_reg         <= iw_next;
            bits_reg       <= bits_next;
            cnt_reg        <= cnt_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            rom_reg        <= rom_next;
            rom_id_reg     <= rom_id_next;
            cand_valid_reg <= cand_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        cand_reg     <= cand_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign rect_x_start = out_reg.x_start;
    assign rect_y_start = out_reg.y_start;
    assign rect_x_end   = out_reg.x_end;
    assign rect_y_end   = out_reg.y_end;
    assign fill_color   = out_reg.color;
    assign last_of_run  = out_last_reg;

endmodule
`default_nettype wire
